[hdl/rhc_pkg.sv]
package rhc_pkg;

    localparam int unsigned QuoBits = 8;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pix_t;

    typedef struct packed {
        logic [8:0] hue_out;
        logic [7:0] saturation_out;
        logic [7:0] value_out;
    } hsv_t;

    typedef struct packed {
        logic [15:0] sat_rem;
        logic [7:0]  sat_div;
        logic [7:0]  sat_quo;
        logic [13:0] hue_rem;
        logic [7:0]  hue_div;
        logic [7:0]  hue_quo;
        logic [8:0]  hue_base;
        logic        hue_neg;
        logic        grey;
        logic [7:0]  value;
    } work_t;

    localparam logic [8:0] BaseRed   = 9'd0;
    localparam logic [8:0] BaseGreen = 9'd120;
    localparam logic [8:0] BaseBlue  = 9'd240;
    localparam logic [9:0] FullTurn  = 10'd360;

endpackage

[hdl/rgb_to_hsv_converter_core.sv]
// Converts one 8-bit RGB word per clock into hue (0..359 degrees), saturation and value.
// Each word passes a front stage that finds the largest and smallest channels, eight
// cells that each settle one quotient bit of both divisions, and the output register
// that holds the result. The whole pipeline halts while a result waits to be taken.
module rgb_to_hsv_converter_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  rhc_pkg::pix_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output rhc_pkg::hsv_t m_data
);

    localparam int unsigned Cells = rhc_pkg::QuoBits;

    logic           enable;
    logic [7:0]     r_val;
    logic [7:0]     g_val;
    logic [7:0]     b_val;
    logic [7:0]     mx;
    logic [7:0]     mn;
    logic [7:0]     delta;
    logic [8:0]     diff;
    logic [7:0]     mag;
    rhc_pkg::work_t front_next;
    rhc_pkg::work_t front_reg;
    logic           front_valid_reg;
    logic           chain_valid [Cells+1];
    rhc_pkg::work_t chain_work  [Cells+1];
    rhc_pkg::work_t tail;
    logic [9:0]     hue_sum;
    logic [9:0]     hue_wrap;
    rhc_pkg::hsv_t  out_next;
    rhc_pkg::hsv_t  out_reg;
    logic           out_valid_reg;

    assign enable  = m_ready || !out_valid_reg;
    assign s_ready = enable;

    always_comb begin
        r_val = s_data.red_in;
        g_val = s_data.green_in;
        b_val = s_data.blue_in;
        mx = (r_val > g_val) ? ((r_val > b_val) ? r_val : b_val)
                             : ((g_val > b_val) ? g_val : b_val);
        mn = (r_val < g_val) ? ((r_val < b_val) ? r_val : b_val)
                             : ((g_val < b_val) ? g_val : b_val);
        delta = mx - mn;
        front_next = '0;
        if (mx == r_val) begin
            diff = {1'b0, g_val} - {1'b0, b_val};
            front_next.hue_base = rhc_pkg::BaseRed;
        end else if (mx == g_val) begin
            diff = {1'b0, b_val} - {1'b0, r_val};
            front_next.hue_base = rhc_pkg::BaseGreen;
        end else begin
            diff = {1'b0, r_val} - {1'b0, g_val};
            front_next.hue_base = rhc_pkg::BaseBlue;
        end
        mag = diff[8] ? 8'(-diff) : diff[7:0];
        front_next.hue_neg = diff[8];
        front_next.sat_rem = {delta, 8'h00} - {8'h00, delta};
        front_next.sat_div = mx;
        front_next.hue_rem = {mag, 6'b000000} - {4'h0, mag, 2'b00};
        front_next.hue_div = delta;
        front_next.grey    = (delta == 8'd0);
        front_next.value   = mx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else if (enable) begin
            front_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            front_reg <= front_next;
        end
    end

    assign chain_valid[0] = front_valid_reg;
    assign chain_work[0]  = front_reg;

    for (genvar i = 0; i < Cells; i++) begin : g_cell
        rhc_div_cell #(
            .BIT(Cells - 1 - i)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .enable   (enable),
            .valid_in (chain_valid[i]),
            .work_in  (chain_work[i]),
            .valid_out(chain_valid[i+1]),
            .work_out (chain_work[i+1])
        );
    end

    always_comb begin
        tail     = chain_work[Cells];
        hue_sum  = tail.hue_neg ? ({1'b0, tail.hue_base} - {2'b00, tail.hue_quo})
                                : ({1'b0, tail.hue_base} + {2'b00, tail.hue_quo});
        hue_wrap = hue_sum[9] ? (hue_sum + rhc_pkg::FullTurn) : hue_sum;
        out_next.value_out = tail.value;
        if (tail.grey) begin
            out_next.hue_out        = 9'd0;
            out_next.saturation_out = 8'd0;
        end else begin
            out_next.hue_out        = hue_wrap[8:0];
            out_next.saturation_out = tail.sat_quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (enable) begin
            out_valid_reg <= chain_valid[Cells];
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

[hdl/rhc_div_cell.sv]
module rhc_div_cell #(
    parameter int unsigned BIT = 7
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          enable,
    input  logic          valid_in,
    input  rhc_pkg::work_t work_in,
    output logic          valid_out,
    output rhc_pkg::work_t work_out
);

    logic           valid_reg;
    logic           valid_next;
    rhc_pkg::work_t work_reg;
    rhc_pkg::work_t work_next;
    logic [15:0]    sat_trial;
    logic [15:0]    hue_trial;
    logic [15:0]    hue_rem_wide;
    logic [15:0]    hue_rem_diff;

    always_comb begin
        sat_trial    = 16'(work_in.sat_div) << BIT;
        hue_trial    = 16'(work_in.hue_div) << BIT;
        hue_rem_wide = {2'b00, work_in.hue_rem};
        hue_rem_diff = hue_rem_wide - hue_trial;
        work_next    = work_in;
        valid_next   = valid_in;
        if (work_in.sat_rem >= sat_trial) begin
            work_next.sat_rem      = work_in.sat_rem - sat_trial;
            work_next.sat_quo[BIT] = 1'b1;
        end
        if (hue_rem_wide >= hue_trial) begin
            work_next.hue_rem      = hue_rem_diff[13:0];
            work_next.hue_quo[BIT] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (enable) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            work_reg <= work_next;
        end
    end

    assign valid_out = valid_reg;
    assign work_out  = work_reg;

endmodule

[hdl/rhc_checker.sv]
module rhc_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input rhc_pkg::pix_t s_data,
    input logic          m_valid,
    input logic          m_ready,
    input rhc_pkg::hsv_t m_data
);

    // A stalled input word keeps its place and its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input word dropped or changed while stalled");

    // A stalled result word keeps its place and its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word dropped or changed while stalled");

    // Hue never reaches a full turn.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.hue_out < 9'd360)
        else $error("hue out of range");

    // A black pixel has no hue and no saturation.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.value_out == 8'd0 |->
            m_data.hue_out == 9'd0 && m_data.saturation_out == 8'd0)
        else $error("black pixel with colour");

    // The input side is held off only while a result waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input held off without back-pressure");

endmodule

bind rgb_to_hsv_converter_core rhc_checker u_rhc_checker (
    .aclk   (aclk),
    .aresetn(aresetn),
    .s_valid(s_valid),
    .s_ready(s_ready),
    .s_data (s_data),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_data (m_data)
);
